// File: design/minv_pkg.sv
// Shared constants for the modular inverse unit.
package minv_pkg;

    // Default operand and modulus width
    localparam int WORD_BITS = 32;

    // Modulus register value after reset, truncated to the word width where used
    localparam logic [63:0] MODULUS_RESET = 64'd65537;

    // Configuration register indexes
    localparam int REG_MODULUS = 0;

endpackage

// File: design/minv_in_if.sv
// Operand channel interface: valid/ready handshake carrying one value.
interface minv_in_if #(
    parameter int WORD_BITS = minv_pkg::WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: design/minv_out_if.sv
// Result channel interface: valid/ready handshake carrying inverse and flag.
interface minv_out_if #(
    parameter int WORD_BITS = minv_pkg::WORD_BITS
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] inverse;
    logic                 no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

// File: design/minv_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
module minv_divider #(
    parameter int WORD_BITS = minv_pkg::WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder
);
    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] dsr_reg;

    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS+1:0] diff;
    logic                 fits;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] quo_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[WORD_BITS-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        fits     = !diff[WORD_BITS+1];
        rem_next = fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        quo_next = {quo_reg[WORD_BITS-2:0], fits};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(WORD_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands on start, advance one bit while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

// File: design/minv_mulmod.sv
// Iterative modular multiplier: LSB-first shift and add, stops when the multiplier runs out.
module minv_mulmod #(
    parameter int WORD_BITS = minv_pkg::WORD_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] multiplicand,
    input  logic [WORD_BITS-1:0] multiplier,
    input  logic [WORD_BITS-1:0] modulus,
    output logic                 done,
    output logic [WORD_BITS-1:0] product
);
    logic                 busy_reg;
    logic                 done_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] mlt_reg;
    logic [WORD_BITS-1:0] mod_reg;

    logic [WORD_BITS:0]   acc_sum;
    logic [WORD_BITS:0]   base_sum;
    logic [WORD_BITS-1:0] acc_next;
    logic [WORD_BITS-1:0] base_next;

    // Two independent modular adds: acc + base and base + base
    always_comb
    begin
        acc_sum  = {1'b0, acc_reg} + {1'b0, base_reg};
        base_sum = {1'b0, base_reg} + {1'b0, base_reg};
        if (acc_sum >= {1'b0, mod_reg})
            acc_next = WORD_BITS'(acc_sum - {1'b0, mod_reg});
        else
            acc_next = acc_sum[WORD_BITS-1:0];
        if (base_sum >= {1'b0, mod_reg})
            base_next = WORD_BITS'(base_sum - {1'b0, mod_reg});
        else
            base_next = base_sum[WORD_BITS-1:0];
    end

    // Sequence control: finish once no multiplier bits remain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && (mlt_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            base_reg <= multiplicand;
            mlt_reg  <= multiplier;
            mod_reg  <= modulus;
        end
        else if (busy_reg && (mlt_reg != '0))
        begin
            if (mlt_reg[0])
                acc_reg <= acc_next;
            base_reg <= base_next;
            mlt_reg  <= mlt_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// File: design/modular_inverse_unit.sv
// Top level of the modular inverse unit: register port, Euclid sequencer and result register.
//
// Returns the inverse of each operand value modulo the programmed modulus by the extended
// Euclidean algorithm, with the Bezout coefficient kept reduced modulo the modulus. When no
// inverse exists (value zero or sharing a factor with the modulus, or modulus zero) the result
// is 0 with no_inverse set; a modulus of one gives 0 with no_inverse clear. One operand is in
// flight at a time. Accepting an operand starts the reduction of the operand modulo the
// modulus; each Euclid quotient step then runs the shared bit-serial divider and then the
// bit-serial modular multiplier, and a last check state and the finish state move the
// answer to the result register. The finish state repeats while an earlier answer still
// waits in the result register. At 32 bits a typical operand needs about 20 quotient steps
// and the worst case about 46; modulus zero or one skips the divider and goes straight to
// the finish state. The result register lets the next operand be taken while the previous
// answer waits. The modulus register sits at byte address 0; the user must see that it is
// written only while the unit is idle, as the unit itself does not enforce this.
module modular_inverse_unit #(
    parameter int WORD_BITS = minv_pkg::WORD_BITS,
    localparam int PDATA_BITS = (WORD_BITS > 32) ? 64 : 32,
    localparam int ADDR_LSB = (WORD_BITS > 32) ? 3 : 2,
    localparam int PADDR_BITS = ADDR_LSB + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    minv_in_if.sink               operand,
    minv_out_if.source            result
);
    import minv_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [WORD_BITS-1:0] modulus_reg;
    logic [2:0]           state_reg, state_next;
    logic [WORD_BITS-1:0] r_prev_reg, r_prev_next;
    logic [WORD_BITS-1:0] r_cur_reg, r_cur_next;
    logic [WORD_BITS-1:0] r_new_reg, r_new_next;
    logic [WORD_BITS-1:0] t_prev_reg, t_prev_next;
    logic [WORD_BITS-1:0] t_cur_reg, t_cur_next;
    logic [WORD_BITS-1:0] fin_inv_reg, fin_inv_next;
    logic                 fin_none_reg, fin_none_next;
    logic                 res_valid_reg, res_valid_next;
    logic [WORD_BITS-1:0] res_inv_reg;
    logic                 res_none_reg;

    logic                 reg_sel;
    logic                 cfg_write;
    logic                 accept;
    logic                 res_load;

    logic                 div_start;
    logic [WORD_BITS-1:0] div_dividend;
    logic [WORD_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [WORD_BITS-1:0] div_quo;
    logic [WORD_BITS-1:0] div_rem;

    logic                 mul_start;
    logic [WORD_BITS-1:0] mul_multiplier;
    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_product;
    logic [WORD_BITS-1:0] t_step;

    // Register port decode
    assign reg_sel   = (paddr[PADDR_BITS-1:ADDR_LSB] == 1'(REG_MODULUS));
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = reg_sel ? PDATA_BITS'(modulus_reg) : '0;

    // Modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MODULUS_RESET[WORD_BITS-1:0];
        else if (cfg_write && reg_sel)
            modulus_reg <= pwdata[WORD_BITS-1:0];
    end

    assign accept         = operand.valid && operand.ready;
    assign operand.ready  = (state_reg == ST_IDLE);
    assign res_load       = (state_reg == ST_FINISH) && (!res_valid_reg || result.ready);

    // New coefficient: t_prev - q * t_cur, kept in [0, modulus)
    assign t_step = (t_prev_reg >= mul_product)
                  ? (t_prev_reg - mul_product)
                  : (t_prev_reg - mul_product + modulus_reg);

    // Euclid sequencer
    always_comb
    begin
        state_next     = state_reg;
        r_prev_next    = r_prev_reg;
        r_cur_next     = r_cur_reg;
        r_new_next     = r_new_reg;
        t_prev_next    = t_prev_reg;
        t_cur_next     = t_cur_reg;
        fin_inv_next   = fin_inv_reg;
        fin_none_next  = fin_none_reg;
        div_start      = 1'b0;
        div_dividend   = r_prev_reg;
        div_divisor    = r_cur_reg;
        mul_start      = 1'b0;
        mul_multiplier = (div_quo == modulus_reg) ? '0 : div_quo;
        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = operand.value;
                div_divisor  = modulus_reg;
                if (accept)
                begin
                    if (modulus_reg == '0)
                    begin
                        fin_inv_next  = '0;
                        fin_none_next = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else if (modulus_reg == WORD_BITS'(1))
                    begin
                        fin_inv_next  = '0;
                        fin_none_next = 1'b0;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (div_done)
                begin
                    r_prev_next = modulus_reg;
                    r_cur_next  = div_rem;
                    t_prev_next = '0;
                    t_cur_next  = WORD_BITS'(1);
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (r_cur_reg == '0)
                begin
                    if (r_prev_reg == WORD_BITS'(1))
                    begin
                        fin_inv_next  = t_prev_reg;
                        fin_none_next = 1'b0;
                    end
                    else
                    begin
                        fin_inv_next  = '0;
                        fin_none_next = 1'b1;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    r_new_next = div_rem;
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    r_prev_next = r_cur_reg;
                    r_cur_next  = r_new_reg;
                    t_prev_next = t_cur_reg;
                    t_cur_next  = t_step;
                    state_next  = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid: set on load, drop after transfer
    always_comb
    begin
        if (res_load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working values and result payload
    always_ff @(posedge clk)
    begin
        r_prev_reg   <= r_prev_next;
        r_cur_reg    <= r_cur_next;
        r_new_reg    <= r_new_next;
        t_prev_reg   <= t_prev_next;
        t_cur_reg    <= t_cur_next;
        fin_inv_reg  <= fin_inv_next;
        fin_none_reg <= fin_none_next;
        if (res_load)
        begin
            res_inv_reg  <= fin_inv_reg;
            res_none_reg <= fin_none_reg;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.inverse    = res_inv_reg;
    assign result.no_inverse = res_none_reg;

    // Shared bit-serial divider
    minv_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Bit-serial modular multiplier for q * t_cur
    minv_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (t_cur_reg),
        .multiplier   (mul_multiplier),
        .modulus      (modulus_reg),
        .done         (mul_done),
        .product      (mul_product)
    );
endmodule
